/* rtl/kdr_pkg.sv */
// Shared types and constants for the key debounce and repeat block.
package kdr_pkg;

  localparam int unsigned NumKeysDef = 16;
  localparam int unsigned LevelW     = 16;
  localparam int unsigned StampW     = 32;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned KeyW       = 4;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 8;

  localparam logic [StampW-1:0] IdleStamp = '1;

  localparam logic [CfgIdxW-1:0] CfgKeysInUse    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceTime = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatPeriod = 2'd2;

  localparam logic [4:0]      KeysInUseRst    = 5'd16;
  localparam logic [CfgW-1:0] DebounceTimeRst = 16'd20;
  localparam logic [CfgW-1:0] RepeatPeriodRst = 16'd500;

  // Request to the shared timestamp adder: y = now - b or now + b.
  typedef struct packed {
    logic              sub;
    logic [StampW-1:0] b;
  } alu_req_t;

endpackage

/* rtl/key_debounce_repeat_select_top.sv */
// Top level: scan sequencer for key debounce, active key selection and repeat.
// Flow: an accepted scan passes each key in use through the stamp memory, then
//   a decide step, and a due step when a repeat deadline is recomputed; events
//   then leave one per accepted output request. A new scan is taken only once
//   the previous scan has emitted its events and the sequencer is back in idle.
// Reset: stable levels clear, debounce stamps read idle, no active key,
//   registers return to 16 keys, 20 ms debounce and 500 ms repeat period.
module key_debounce_repeat_select_top #(
  parameter int unsigned KEY_SLOTS = kdr_pkg::NumKeysDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kdr_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [15:0] key_levels, [47:16] now_time
  input  logic [kdr_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [3:0] event_key, [4] event_pressed, [7:5] zero
  output logic [kdr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(KEY_SLOTS + 1);
  localparam int unsigned CmpW = (CntW > 5) ? CntW : 5;
  localparam int unsigned SW   = kdr_pkg::StampW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_KEY    = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DUE    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  logic [4:0]              kiu_q;
  logic [kdr_pkg::CfgW-1:0] deb_q, per_q;

  logic [kdr_pkg::LevelW-1:0] lev_q;
  logic [SW-1:0]              now_q;
  logic [CntW-1:0]            cnt_q;
  logic [CntW-1:0]            key_q, key_d;
  logic [KEY_SLOTS-1:0]       stable_q, stable_d;
  logic                       found_q, found_d;
  logic [IdxW-1:0]            first_q, first_d;
  logic                       act_v_q, act_v_d;
  logic [IdxW-1:0]            act_idx_q, act_idx_d;
  logic [SW-1:0]              due_q, due_d;
  logic [1:0]                 ev_n_q, ev_n_d;
  logic                       pos_q, pos_d;
  logic [IdxW-1:0]            ev0_key_q, ev0_key_d, ev1_key_q, ev1_key_d;
  logic                       ev0_prs_q, ev0_prs_d, ev1_prs_q, ev1_prs_d;

  logic [CmpW-1:0] kiu_ext, nk_ext, cnt_full;
  logic [CntW-1:0] scan_cnt, key_nxt;
  logic [IdxW-1:0] key_idx;
  logic [kdr_pkg::LevelW-1:0] lev_sh;
  logic            raw, stable_cur, new_lvl, deb_ge, act_lvl;
  logic [SW-1:0]   rd_stamp, start, alu_y;
  logic            mem_we, mem_clr;
  kdr_pkg::alu_req_t alu_req;
  logic            in_acc, out_acc, out_last;
  logic [IdxW-1:0] out_key;
  logic            out_prs;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kiu_q <= kdr_pkg::KeysInUseRst;
      deb_q <= kdr_pkg::DebounceTimeRst;
      per_q <= kdr_pkg::RepeatPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdr_pkg::CfgKeysInUse:    kiu_q <= cfg_wdata_i[4:0];
        kdr_pkg::CfgDebounceTime: deb_q <= cfg_wdata_i;
        kdr_pkg::CfgRepeatPeriod: per_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign kiu_ext  = CmpW'(kiu_q);
  assign nk_ext   = CmpW'(KEY_SLOTS);
  assign cnt_full = (kiu_ext > nk_ext) ? nk_ext : kiu_ext;
  assign scan_cnt = CntW'(cnt_full);

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign key_idx    = key_q[IdxW-1:0];
  assign key_nxt    = key_q + CntW'(1);
  // Keys beyond the input width shift out to level zero
  assign lev_sh     = lev_q >> key_q;
  assign raw        = lev_sh[0];
  assign stable_cur = stable_q[key_idx];
  assign start      = (rd_stamp == kdr_pkg::IdleStamp) ? now_q : rd_stamp;
  assign deb_ge     = (alu_y[SW-1:16] != '0) || (alu_y[15:0] >= deb_q);
  assign new_lvl    = (raw != stable_cur && deb_ge) ? raw : stable_cur;
  assign act_lvl    = stable_q[act_idx_q];

  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.b   = start;
    unique case (state_q)
      S_DECIDE: alu_req.b = due_q;
      S_DUE: begin
        alu_req.sub = 1'b0;
        alu_req.b   = SW'(per_q);
      end
      default: ;
    endcase
  end

  kdr_alu u_alu (
    .a_i   (now_q),
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  assign mem_we  = (state_q == S_KEY) && (raw != stable_cur) && !deb_ge;
  assign mem_clr = (state_q == S_KEY) && !mem_we;

  kdr_stamp_ram #(
    .Depth (KEY_SLOTS),
    .AddrW (IdxW)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .clr_i   (mem_clr),
    .waddr_i (key_idx),
    .wdata_i (start),
    .raddr_i ((state_q == S_KEY) ? key_nxt[IdxW-1:0] : '0),
    .rdata_o (rd_stamp)
  );

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    stable_d  = stable_q;
    found_d   = found_q;
    first_d   = first_q;
    act_v_d   = act_v_q;
    act_idx_d = act_idx_q;
    due_d     = due_q;
    ev_n_d    = ev_n_q;
    pos_d     = pos_q;
    ev0_key_d = ev0_key_q;
    ev0_prs_d = ev0_prs_q;
    ev1_key_d = ev1_key_q;
    ev1_prs_d = ev1_prs_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d   = '0;
          found_d = 1'b0;
          state_d = (scan_cnt == '0) ? S_DECIDE : S_KEY;
        end
      end
      S_KEY: begin
        stable_d[key_idx] = new_lvl;
        if (new_lvl && !found_q) begin
          found_d = 1'b1;
          first_d = key_idx;
        end
        key_d = key_nxt;
        if (key_nxt == cnt_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ev_n_d  = 2'd0;
        pos_d   = 1'b0;
        state_d = S_IDLE;
        if (!act_v_q) begin
          if (found_q) begin
            ev0_key_d = first_q;
            ev0_prs_d = 1'b1;
            ev_n_d    = 2'd1;
            act_v_d   = 1'b1;
            act_idx_d = first_q;
            state_d   = S_DUE;
          end
        end else if (!act_lvl) begin
          ev0_key_d = act_idx_q;
          ev0_prs_d = 1'b0;
          ev_n_d    = 2'd1;
          act_v_d   = 1'b0;
          state_d   = S_EMIT;
          if (found_q) begin
            ev1_key_d = first_q;
            ev1_prs_d = 1'b1;
            ev_n_d    = 2'd2;
            act_v_d   = 1'b1;
            act_idx_d = first_q;
            state_d   = S_DUE;
          end
        end else if (!alu_y[SW-1]) begin
          ev0_key_d = act_idx_q;
          ev0_prs_d = 1'b1;
          ev_n_d    = 2'd1;
          state_d   = S_DUE;
        end
      end
      S_DUE: begin
        due_d   = alu_y;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          pos_d = 1'b1;
          if (out_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      key_q     <= '0;
      stable_q  <= '0;
      found_q   <= 1'b0;
      act_v_q   <= 1'b0;
      act_idx_q <= '0;
      due_q     <= '0;
      ev_n_q    <= '0;
      pos_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      key_q     <= key_d;
      stable_q  <= stable_d;
      found_q   <= found_d;
      act_v_q   <= act_v_d;
      act_idx_q <= act_idx_d;
      due_q     <= due_d;
      ev_n_q    <= ev_n_d;
      pos_q     <= pos_d;
    end
  end

  // Scan payload and event payload need no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lev_q <= s_axis_tdata[15:0];
      now_q <= s_axis_tdata[47:16];
      cnt_q <= scan_cnt;
    end
    first_q   <= first_d;
    ev0_key_q <= ev0_key_d;
    ev0_prs_q <= ev0_prs_d;
    ev1_key_q <= ev1_key_d;
    ev1_prs_q <= ev1_prs_d;
  end

  assign out_key  = pos_q ? ev1_key_q : ev0_key_q;
  assign out_prs  = pos_q ? ev1_prs_q : ev0_prs_q;
  assign out_last = pos_q || (ev_n_q == 2'd1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign m_axis_tdata  = {3'b000, out_prs, kdr_pkg::KeyW'(out_key)};
  assign m_axis_tlast  = out_last;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while events pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("ready right after accepting a scan");

  a_press_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && m_axis_tdata[4]) |-> act_v_q)
    else $error("press event without active key");

  a_release_clears_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && !m_axis_tdata[4]) |-> !act_v_q)
    else $error("release event left key active");

  a_key_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KEY) |-> (key_q < cnt_q))
    else $error("key pass ran beyond keys in use");

endmodule

/* rtl/kdr_alu.sv */
// Shared 32-bit timestamp adder/subtractor.
module kdr_alu (
  input  logic [kdr_pkg::StampW-1:0] a_i,
  input  kdr_pkg::alu_req_t          req_i,
  output logic [kdr_pkg::StampW-1:0] y_o
);

  assign y_o = req_i.sub ? (a_i - req_i.b) : (a_i + req_i.b);

endmodule

/* rtl/kdr_stamp_ram.sv */
// Debounce start stamp memory with per-entry valid bits; invalid reads as idle.
module kdr_stamp_ram #(
  parameter int unsigned Depth = kdr_pkg::NumKeysDef,
  parameter int unsigned AddrW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic                       clr_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [kdr_pkg::StampW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [kdr_pkg::StampW-1:0] rdata_o
);

  logic [kdr_pkg::StampW-1:0] mem [Depth];
  logic [Depth-1:0]           valid_q;
  logic [kdr_pkg::StampW-1:0] rdata_q;
  logic                       rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end else if (clr_i) begin
        valid_q[waddr_i] <= 1'b0;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : kdr_pkg::IdleStamp;

endmodule

/* tb/sv/key_debounce_repeat_select_top_test.sv */
// Self-checking testbench for the key debounce and repeat block, with a scoreboard class.
module key_debounce_repeat_select_top_test;

  localparam int unsigned NumKeys      = kdr_pkg::NumKeysDef;
  localparam logic [kdr_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned WatchLimit   = 4000;

  typedef struct {
    logic [kdr_pkg::KeyW-1:0] key;
    logic                     pressed;
    logic                     last;
  } key_evt_t;

  class key_event_scoreboard;
    logic [4:0]                keys_in_use;
    logic [kdr_pkg::CfgW-1:0]  deb_period;
    logic [kdr_pkg::CfgW-1:0]  rpt_period;
    logic                      stable_lvl [NumKeys];
    logic [kdr_pkg::StampW-1:0] change_stamp [NumKeys];
    bit                        active_valid;
    logic [kdr_pkg::KeyW-1:0]  act_key;
    logic [kdr_pkg::StampW-1:0] rpt_deadline;
    key_evt_t                  due_events [$];
    int                        mismatches;

    function new();
      keys_in_use  = kdr_pkg::KeysInUseRst;
      deb_period   = kdr_pkg::DebounceTimeRst;
      rpt_period   = kdr_pkg::RepeatPeriodRst;
      for (int i = 0; i < NumKeys; i++) begin
        stable_lvl[i]   = 1'b0;
        change_stamp[i] = kdr_pkg::IdleStamp;
      end
      active_valid = 1'b0;
      act_key      = '0;
      rpt_deadline = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [kdr_pkg::CfgIdxW-1:0] idx, logic [kdr_pkg::CfgW-1:0] val);
      case (idx)
        kdr_pkg::CfgKeysInUse:    keys_in_use = val[4:0];
        kdr_pkg::CfgDebounceTime: deb_period  = val;
        kdr_pkg::CfgRepeatPeriod: rpt_period  = val;
        default: ;
      endcase
    endfunction

    function int unsigned scanned_keys();
      return (keys_in_use > NumKeys) ? NumKeys : keys_in_use;
    endfunction

    function void push_evt(logic [kdr_pkg::KeyW-1:0] key, logic pressed);
      key_evt_t e;
      e.key     = key;
      e.pressed = pressed;
      e.last    = 1'b0;
      due_events.push_back(e);
    endfunction

    // Make the lowest committed pressed key active.
    function void pick_pressed(logic [kdr_pkg::StampW-1:0] now);
      for (int i = 0; i < scanned_keys(); i++) begin
        if (stable_lvl[i]) begin
          active_valid = 1'b1;
          act_key      = i[kdr_pkg::KeyW-1:0];
          rpt_deadline = now + {16'd0, rpt_period};
          push_evt(i[kdr_pkg::KeyW-1:0], 1'b1);
          return;
        end
      end
    endfunction

    function void note_scan(logic [kdr_pkg::LevelW-1:0] levels, logic [kdr_pkg::StampW-1:0] now);
      logic [kdr_pkg::StampW-1:0] diff;
      int                         first;
      first = due_events.size();
      for (int i = 0; i < scanned_keys(); i++) begin
        if (levels[i] != stable_lvl[i]) begin
          if (change_stamp[i] == kdr_pkg::IdleStamp) change_stamp[i] = now;
          diff = now - change_stamp[i];
          if (diff >= {16'd0, deb_period}) begin
            stable_lvl[i]   = levels[i];
            change_stamp[i] = kdr_pkg::IdleStamp;
          end
        end else begin
          change_stamp[i] = kdr_pkg::IdleStamp;
        end
      end
      if (!active_valid) begin
        pick_pressed(now);
      end else if (!stable_lvl[act_key]) begin
        push_evt(act_key, 1'b0);
        active_valid = 1'b0;
        pick_pressed(now);
      end else begin
        diff = now - rpt_deadline;
        if (!diff[31]) begin
          rpt_deadline = now + {16'd0, rpt_period};
          push_evt(act_key, 1'b1);
        end
      end
      if (due_events.size() > first) due_events[due_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(logic [kdr_pkg::KeyW-1:0] key, logic pressed, logic last);
      key_evt_t want;
      if (due_events.size() == 0) begin
        mismatches++;
        $error("unexpected event: key %0d pressed %0b last %0b", key, pressed, last);
        return;
      end
      want = due_events.pop_front();
      if (want.key !== key) begin
        mismatches++;
        $error("event_key: expected %0d, got %0d", want.key, key);
      end
      if (want.pressed !== pressed) begin
        mismatches++;
        $error("event_pressed: expected %0b, got %0b", want.pressed, pressed);
      end
      if (want.last !== last) begin
        mismatches++;
        $error("last_event: expected %0b, got %0b", want.last, last);
      end
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [kdr_pkg::CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [kdr_pkg::CfgW-1:0]      cfg_wdata_i   = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [kdr_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [kdr_pkg::OutDataW-1:0]  m_axis_tdata;
  logic                          m_axis_tlast;

  key_event_scoreboard board = new();

  bit                          no_stall   = 1'b0;
  int                          ready_left = 0;
  int                          idle_cycles = 0;
  logic [kdr_pkg::StampW-1:0]  clock_ms   = '0;
  logic [kdr_pkg::LevelW-1:0]  held_mask  = '0;
  int                          hold_left  = 0;

  key_debounce_repeat_select_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Output backpressure: mostly short stalls, now and then a long one.
  always @(negedge clk_i) begin : ready_drive
    int pick;
    if (ready_left > 0) begin
      ready_left--;
    end else if (no_stall) begin
      m_axis_tready = 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        m_axis_tready = 1'b1;
        ready_left    = $urandom_range(0, 7);
      end else if (pick < 92) begin
        m_axis_tready = 1'b0;
        ready_left    = $urandom_range(0, 2);
      end else begin
        m_axis_tready = 1'b0;
        ready_left    = $urandom_range(9, 39);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_event(m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("key_debounce_repeat_select_top: mismatch");
      $finish;
    end
  end

  function automatic int pick_gap();
    int pick;
    if (no_stall) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_scan(logic [kdr_pkg::LevelW-1:0] levels, logic [kdr_pkg::StampW-1:0] now);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {now, levels};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_scan(levels, now);
  endtask

  task automatic write_reg(logic [kdr_pkg::CfgIdxW-1:0] idx, logic [kdr_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.write_reg(idx, val);
  endtask

  // Wait out every expected event, then let a scan with no events finish.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.due_events.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic run_scans(int count, int step_max, int hold_max, int key_span);
    logic [kdr_pkg::LevelW-1:0] levels;
    int                         pick;
    for (int n = 0; n < count; n++) begin
      if (hold_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          held_mask ^= 16'd1 << $urandom_range(0, key_span - 1);
        end else if (pick < 70) begin
          held_mask ^= 16'd1 << $urandom_range(0, key_span - 1);
          held_mask ^= 16'd1 << $urandom_range(0, 15);
        end else if (pick < 85) begin
          held_mask = '0;
        end else if (pick < 95) begin
          held_mask = kdr_pkg::LevelW'($urandom);
        end else begin
          held_mask = '1;
        end
        hold_left = $urandom_range(1, hold_max);
      end
      hold_left--;
      levels = held_mask;
      // Add contact bounce on one key, or a scan of pure noise.
      pick = $urandom_range(0, 99);
      if (pick < 15) levels ^= 16'd1 << $urandom_range(0, key_span - 1);
      else if (pick < 20) levels = kdr_pkg::LevelW'($urandom);
      clock_ms += $urandom_range(0, step_max);
      if ($urandom_range(0, 49) == 0) clock_ms += $urandom;
      send_scan(levels, clock_ms);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Debounce started at the all-ones stamp restarts on the next scan.
    send_scan(16'h0000, 32'h0000_0000);
    send_scan(16'hFFFF, 32'hFFFF_FFFF);
    send_scan(16'hFFFF, 32'd10);
    send_scan(16'hFFFF, 32'd30);
    send_scan(16'hFFFF, 32'd529);
    send_scan(16'hFFFF, 32'd530);
    send_scan(16'hFFFE, 32'd531);
    send_scan(16'hFFFE, 32'd551);
    send_scan(16'h8000, 32'd560);
    send_scan(16'h8000, 32'd580);
    // Repeat deadline exactly half the stamp range away: negative, then not.
    send_scan(16'h8000, 32'd1080 + 32'h8000_0000);
    send_scan(16'h8000, 32'd1080 + 32'h7FFF_FFFF);
    send_scan(16'h0000, 32'h100);
    send_scan(16'h0000, 32'h113);
    send_scan(16'h0000, 32'h114);
    send_scan(16'h0001, 32'h200);
    send_scan(16'h0000, 32'h210);
    send_scan(16'h0001, 32'h220);
    send_scan(16'h0001, 32'h234);
    send_scan(16'h0000, 32'hFFFF_FFFF);
    send_scan(16'h0000, 32'h13);
    send_scan(16'h0000, 32'h27);
    clock_ms = 32'h1000;
    run_scans(160, 40, 30, 16);

    drain();
    write_reg(kdr_pkg::CfgKeysInUse, 16'h0025);
    write_reg(kdr_pkg::CfgDebounceTime, 16'd0);
    write_reg(kdr_pkg::CfgRepeatPeriod, 16'd0);
    write_reg(CfgUnused, 16'hFFFF);
    run_scans(150, 3, 8, 5);

    drain();
    write_reg(kdr_pkg::CfgKeysInUse, 16'd31);
    write_reg(kdr_pkg::CfgDebounceTime, 16'hFFFF);
    write_reg(kdr_pkg::CfgRepeatPeriod, 16'hFFFF);
    run_scans(130, 25000, 12, 16);

    drain();
    no_stall = 1'b1;
    write_reg(kdr_pkg::CfgKeysInUse, 16'd1);
    write_reg(kdr_pkg::CfgDebounceTime, 16'd3);
    write_reg(kdr_pkg::CfgRepeatPeriod, 16'd7);
    run_scans(120, 3, 15, 1);

    drain();
    no_stall = 1'b0;
    write_reg(kdr_pkg::CfgKeysInUse, 16'd0);
    run_scans(40, 50, 5, 16);

    drain();
    write_reg(kdr_pkg::CfgKeysInUse, 16'd16);
    write_reg(kdr_pkg::CfgDebounceTime, 16'd10);
    write_reg(kdr_pkg::CfgRepeatPeriod, 16'd30);
    clock_ms = 32'hFFFF_FF00;
    run_scans(170, 8, 20, 16);

    drain();
    write_reg(kdr_pkg::CfgKeysInUse, 16'd8);
    write_reg(kdr_pkg::CfgDebounceTime, 16'd1);
    write_reg(kdr_pkg::CfgRepeatPeriod, 16'd2);
    run_scans(130, 2, 10, 8);

    drain();
    if (board.mismatches == 0 && board.due_events.size() == 0) begin
      $display("key_debounce_repeat_select_top: match");
    end else begin
      $display("key_debounce_repeat_select_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/kdr_pkg.sv
rtl/kdr_alu.sv
rtl/kdr_stamp_ram.sv
rtl/key_debounce_repeat_select_top.sv
tb/sv/key_debounce_repeat_select_top_test.sv
